[design/scb_pkg.sv]
// Shared constants and types of the shelf cascade crossfade boost block.
`default_nettype none
package scb_pkg;

	localparam int HISTORY_DEPTH_D = 4096;
	localparam int MODE_COUNT_D    = 6;
	localparam int SAMPLE_BITS_D   = 24;
	localparam int COEF_BITS_D     = 32;

	localparam int MEM_BITS   = 40;
	localparam int SIG_FRAC   = 8;
	localparam int GAIN_W     = 32;
	localparam int BOOST_W    = 24;
	localparam int CIDX_W     = 6;
	localparam int SEL_W      = 2;
	localparam int MODE_W     = 3;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int HLEN_W     = 13;
	localparam int LEN16_W    = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_CTRL   = 2'd1,
		REQ_COEF   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH    = 2'd2;

	typedef enum logic [15:0] {
		ST_IDLE     = 16'h0001,
		ST_RP_RD    = 16'h0002,
		ST_RP_WAIT  = 16'h0004,
		ST_F_RD     = 16'h0008,
		ST_F_LO     = 16'h0010,
		ST_F_HI     = 16'h0020,
		ST_F_ACC    = 16'h0040,
		ST_XF_MUL   = 16'h0080,
		ST_XF_SET   = 16'h0100,
		ST_DIV      = 16'h0200,
		ST_XF_END   = 16'h0400,
		ST_GAIN_END = 16'h0800,
		ST_FIN      = 16'h1000,
		ST_G_LO     = 16'h2000,
		ST_G_HI     = 16'h4000,
		ST_G_OUT    = 16'h8000
	} state_t;

	typedef enum logic [1:0] {
		PH_REPLAY = 2'd0,
		PH_ACT    = 2'd1,
		PH_INC    = 2'd2
	} phase_t;

endpackage
`default_nettype wire

[design/scb_ram.sv]
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module scb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[design/shelf_cascade_crossfade_boost.sv]
// Top level: two shelf sections on a shared MAC, history replay, crossfade and gain ramp.
// Audio item: six MAC steps on the shared multiplier, then the gain stage.
// During a crossfade an audio item also takes a second filter pass and the
// 58-step serial divider. A mode change first replays the history, one pass per entry.
// A control item that changes the gain runs the serial divider; other control items do not.
// Reset is asynchronous, active low; the coefficient and history RAMs are not cleared.
`default_nettype none
module shelf_cascade_crossfade_boost #(
	parameter int HISTORY_DEPTH = scb_pkg::HISTORY_DEPTH_D,
	parameter int MODE_COUNT    = scb_pkg::MODE_COUNT_D,
	parameter int SAMPLE_BITS   = scb_pkg::SAMPLE_BITS_D,
	parameter int COEF_BITS     = scb_pkg::COEF_BITS_D,
	localparam int IN_W   = SAMPLE_BITS + 2 + 2 + scb_pkg::BOOST_W + scb_pkg::CIDX_W + COEF_BITS,
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_TW = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// in_sample, amp_type, emphasis_select, boost_gain, coef_index, coef_value
	input  logic [IN_TW-1:0]               s_tdata,
	// req_type
	input  logic [scb_pkg::REQ_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_sample
	output logic [OUT_TW-1:0]              m_tdata,
	input  logic                           cfg_wen,
	input  logic [scb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [scb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import scb_pkg::*;

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int LW    = AW + 1;
	localparam int CA_N  = MODE_COUNT * 6;
	localparam int CA_W  = (CA_N > 1) ? $clog2(CA_N) : 1;
	localparam int MB    = MEM_BITS + 1;
	localparam int CH_W  = (COEF_BITS - 16 > 17) ? COEF_BITS - 16 : 17;
	localparam int PW    = MB + CH_W;
	localparam int RW    = PW + 1;
	localparam int SW    = PW + 2;
	localparam int DVW   = PW;
	localparam int DCW   = $clog2(DVW + 1);
	localparam int O_AMP = SAMPLE_BITS;
	localparam int O_EMP = O_AMP + 2;
	localparam int O_BST = O_EMP + 2;
	localparam int O_CIX = O_BST + BOOST_W;
	localparam int O_CV  = O_CIX + CIDX_W;

	localparam logic signed [SW-1:0] M_MAX = {{(SW-MEM_BITS+1){1'b0}}, {(MEM_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] M_MIN = ~M_MAX;
	localparam logic signed [RW-1:0] O_MAX = {{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [RW-1:0] O_MIN = ~O_MAX;
	localparam logic signed [RW-1:0] HALF_F = RW'(1) <<< 27;
	localparam logic signed [RW-1:0] HALF_G = RW'(1) <<< 35;
	localparam logic [GAIN_W-1:0]    UNITY = GAIN_W'(1) << 28;

	// Configuration registers.
	logic [HLEN_W-1:0]  hist_cfg_q;
	logic [LEN16_W-1:0] fade_cfg_q, ramp_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_cfg_q <= HLEN_W'(1024);
			fade_cfg_q <= LEN16_W'(480);
			ramp_cfg_q <= LEN16_W'(480);
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_HISTORY_LENGTH: hist_cfg_q <= cfg_wdata[HLEN_W-1:0];
				REG_FADE_LENGTH:    fade_cfg_q <= cfg_wdata;
				REG_RAMP_LENGTH:    ramp_cfg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input fields.
	req_t                          req;
	logic signed [SAMPLE_BITS-1:0] in_x;
	logic [1:0]                    amp, emp;
	logic [BOOST_W-1:0]            boost;
	logic [CIDX_W-1:0]             cidx;
	logic [COEF_BITS-1:0]          cval;

	assign req   = req_t'(s_tuser);
	assign in_x  = s_tdata[SAMPLE_BITS-1:0];
	assign amp   = s_tdata[O_AMP +: 2];
	assign emp   = s_tdata[O_EMP +: 2];
	assign boost = s_tdata[O_BST +: BOOST_W];
	assign cidx  = s_tdata[O_CIX +: CIDX_W];
	assign cval  = s_tdata[O_CV +: COEF_BITS];

	// State.
	state_t                        state_q;
	phase_t                        phase_q;
	logic [2:0]                    opi_q;
	logic signed [SAMPLE_BITS-1:0] xs_q;
	logic signed [MB-1:0]          fx_q, yfin_q;
	logic signed [MEM_BITS-1:0]    y_q, yold_q;
	logic signed [RW-1:0]          t_q;
	logic signed [PW-1:0]          p_lo_q, p_hi_q;
	logic signed [CH_W-1:0]        ch_q;
	logic signed [MEM_BITS-1:0]    act_mem_q [2];
	logic signed [MEM_BITS-1:0]    inc_mem_q [2];
	logic [MODE_W-1:0]             act_mode_q, inc_mode_q, want_mode_q;
	logic                          fading_q;
	logic [LEN16_W-1:0]            fade_pos_q;
	logic [GAIN_W-1:0]             gain_now_q, gain_goal_q;
	logic signed [GAIN_W+1:0]      step_q;
	logic [LEN16_W-1:0]            ramp_left_q;
	logic [AW-1:0]                 hpos_q, ridx_q;
	logic [LW-1:0]                 hfill_q, rcnt_q;
	logic [DVW-1:0]                dq_q;
	logic [LEN16_W-1:0]            rem_q, dvs_q;
	logic [DCW-1:0]                dcnt_q;
	logic                          neg_q, div_gain_q;
	logic                          m_tvalid_q;
	logic [SAMPLE_BITS-1:0]        out_q;

	// History length, pointers and replay start.
	logic [LW-1:0] hlen, posc, fillc, np;
	logic [LW:0]   rstart;

	always_comb begin
		if (hist_cfg_q == '0) begin
			hlen = LW'(1);
		end else if (32'(hist_cfg_q) > 32'(HISTORY_DEPTH)) begin
			hlen = LW'(HISTORY_DEPTH);
		end else begin
			hlen = LW'(hist_cfg_q);
		end
		posc   = (LW'(hpos_q) >= hlen) ? '0 : LW'(hpos_q);
		fillc  = (hfill_q > hlen) ? hlen : hfill_q;
		rstart = (LW+1)'(posc) + (LW+1)'(hlen) - (LW+1)'(fillc);
		if (rstart >= (LW+1)'(hlen)) begin
			rstart = rstart - (LW+1)'(hlen);
		end
		np = posc + LW'(1);
		if (np >= hlen) begin
			np = '0;
		end
	end

	// Control item decode.
	logic [1:0]          amp_t;
	logic [MODE_W-1:0]   mode_raw, mode_new;
	logic [BOOST_W-1:0]  boost_c;
	logic [GAIN_W-1:0]   goal;
	logic signed [GAIN_W:0] gdiff;
	logic [GAIN_W:0]     gmag;
	logic [LEN16_W-1:0]  rlen;

	always_comb begin
		amp_t    = (amp == 2'd3) ? 2'd1 : amp;
		mode_raw = {amp_t, (emp[1] ? 1'b0 : emp[0])};
		mode_new = (32'(mode_raw) < MODE_COUNT) ? mode_raw : '0;
		boost_c  = boost[BOOST_W-1:20] == '0 ? BOOST_W'(1) << 20 : boost;
		goal     = {boost_c, 8'd0};
		gdiff    = $signed({1'b0, goal}) - $signed({1'b0, gain_now_q});
		gmag     = gdiff[GAIN_W] ? (GAIN_W+1)'(-gdiff) : (GAIN_W+1)'(gdiff);
		rlen     = (ramp_cfg_q == '0) ? LEN16_W'(1) : ramp_cfg_q;
	end

	// Fade arithmetic.
	logic [LEN16_W-1:0] flen, den, pcl;
	logic               fade_end;

	always_comb begin
		flen     = (fade_cfg_q < LEN16_W'(2)) ? LEN16_W'(2) : fade_cfg_q;
		den      = flen - LEN16_W'(1);
		pcl      = (fade_pos_q < den) ? fade_pos_q : den;
		fade_end = (17'(fade_pos_q) + 17'd1) >= 17'(flen);
	end

	// Memories.
	logic                 coef_we;
	logic [CA_W-1:0]      coef_raddr;
	logic [COEF_BITS-1:0] coef_rdata;
	logic [MODE_W-1:0]    mode_sel;
	logic [SAMPLE_BITS-1:0] hist_rdata;

	assign mode_sel   = (phase_q == PH_ACT) ? act_mode_q : inc_mode_q;
	assign coef_we    = (state_q == ST_IDLE) && s_tvalid && (req == REQ_COEF)
		&& (32'(cidx) < CA_N);
	assign coef_raddr = CA_W'(6'(mode_sel) * 6'd6 + 6'(opi_q));

	scb_ram #(.WIDTH(COEF_BITS), .DEPTH(CA_N)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (CA_W'(cidx)),
		.wdata (cval),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	scb_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (state_q == ST_FIN),
		.waddr (AW'(posc)),
		.wdata (xs_q),
		.raddr (ridx_q),
		.rdata (hist_rdata)
	);

	// Shared multiplier.
	logic signed [MB-1:0]   mul_a;
	logic signed [CH_W-1:0] mul_b;
	logic signed [PW-1:0]   prod;
	logic                   sec;
	logic [1:0]             slot;

	assign sec  = (opi_q >= 3'd3);
	assign slot = sec ? 2'(opi_q - 3'd3) : 2'(opi_q);

	always_comb begin
		mul_a = fx_q;
		mul_b = ch_q;
		unique case (state_q)
			ST_F_LO: begin
				mul_a = (slot == 2'd2) ? MB'(y_q) : fx_q;
				mul_b = $signed(CH_W'(coef_rdata[15:0]));
			end
			ST_F_HI: mul_a = (slot == 2'd2) ? MB'(y_q) : fx_q;
			ST_XF_MUL: begin
				mul_a = fx_q - MB'(yold_q);
				mul_b = $signed(CH_W'(pcl));
			end
			ST_G_LO: begin
				mul_a = yfin_q;
				mul_b = $signed(CH_W'(gain_now_q[15:0]));
			end
			ST_G_HI: begin
				mul_a = yfin_q;
				mul_b = $signed(CH_W'(gain_now_q[GAIN_W-1:16]));
			end
			default: ;
		endcase
		prod = PW'(mul_a) * PW'(mul_b);
	end

	// Rounded shift of the two partial products, then the section update.
	logic signed [RW-1:0]       qv, sumv, res;
	logic signed [MEM_BITS-1:0] mem_k, y_sat, m_sat;
	logic signed [SW-1:0]       y_w, m_w;
	logic [SAMPLE_BITS-1:0]     o_sat;

	always_comb begin
		qv    = RW'(p_lo_q) + ((state_q == ST_G_OUT) ? HALF_G : HALF_F);
		sumv  = RW'(p_hi_q) + (qv >>> 16);
		res   = (state_q == ST_G_OUT) ? (sumv >>> 20) : (sumv >>> 12);
		mem_k = (phase_q == PH_ACT) ? act_mem_q[sec] : inc_mem_q[sec];
		y_w   = SW'(res) + SW'(mem_k);
		m_w   = SW'(t_q) - SW'(res);
		y_sat = (y_w > M_MAX) ? MEM_BITS'(M_MAX) : (y_w < M_MIN) ? MEM_BITS'(M_MIN)
			: MEM_BITS'(y_w);
		m_sat = (m_w > M_MAX) ? MEM_BITS'(M_MAX) : (m_w < M_MIN) ? MEM_BITS'(M_MIN)
			: MEM_BITS'(m_w);
		o_sat = (res > O_MAX) ? SAMPLE_BITS'(O_MAX) : (res < O_MIN) ? SAMPLE_BITS'(O_MIN)
			: SAMPLE_BITS'(res);
	end

	// Divider step and crossfade result.
	logic [LEN16_W:0]     rem_sh;
	logic                 dbit;
	logic [MB-1:0]        qmag;
	logic signed [MB:0]   qsig;
	logic signed [PW-1:0] num_mag;
	logic signed [GAIN_W+1:0] nsum;

	always_comb begin
		rem_sh  = {rem_q, dq_q[DVW-1]};
		dbit    = rem_sh >= {1'b0, dvs_q};
		qmag    = dq_q[MB-1:0];
		qsig    = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		num_mag = p_lo_q[PW-1] ? -p_lo_q : p_lo_q;
		nsum    = $signed({2'b00, gain_now_q}) + step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_ACT;
			opi_q       <= '0;
			xs_q        <= '0;
			fx_q        <= '0;
			yfin_q      <= '0;
			y_q         <= '0;
			yold_q      <= '0;
			t_q         <= '0;
			p_lo_q      <= '0;
			p_hi_q      <= '0;
			ch_q        <= '0;
			act_mem_q   <= '{default: '0};
			inc_mem_q   <= '{default: '0};
			act_mode_q  <= '0;
			inc_mode_q  <= '0;
			want_mode_q <= '0;
			fading_q    <= 1'b0;
			fade_pos_q  <= '0;
			gain_now_q  <= UNITY;
			gain_goal_q <= UNITY;
			step_q      <= '0;
			ramp_left_q <= '0;
			hpos_q      <= '0;
			hfill_q     <= '0;
			ridx_q      <= '0;
			rcnt_q      <= '0;
			dq_q        <= '0;
			rem_q       <= '0;
			dvs_q       <= '0;
			dcnt_q      <= '0;
			neg_q       <= 1'b0;
			div_gain_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
			out_q       <= '0;
		end else begin
			// The output stage sets its own valid when it hands over a new item.
			if (m_tvalid_q && m_tready && state_q != ST_G_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (req)
							REQ_CTRL: begin
								want_mode_q <= mode_new;
								if (goal != gain_goal_q) begin
									gain_goal_q <= goal;
									ramp_left_q <= rlen;
									dq_q        <= DVW'(gmag);
									dvs_q       <= rlen;
									rem_q       <= '0;
									dcnt_q      <= '0;
									neg_q       <= gdiff[GAIN_W];
									div_gain_q  <= 1'b1;
									state_q     <= ST_DIV;
								end
							end
							REQ_SAMPLE: begin
								xs_q <= in_x;
								if (!fading_q && act_mode_q != want_mode_q) begin
									inc_mode_q <= want_mode_q;
									inc_mem_q  <= '{default: '0};
									ridx_q     <= AW'(rstart);
									rcnt_q     <= fillc;
									phase_q    <= PH_REPLAY;
									state_q    <= ST_RP_RD;
								end else begin
									fx_q    <= MB'(in_x) <<< SIG_FRAC;
									opi_q   <= '0;
									phase_q <= PH_ACT;
									state_q <= ST_F_RD;
								end
							end
							REQ_COEF: ;
							REQ_NONE: ;
							default: ;
						endcase
					end
				end
				ST_RP_RD: begin
					if (rcnt_q == '0) begin
						fade_pos_q <= '0;
						fading_q   <= 1'b1;
						fx_q       <= MB'(xs_q) <<< SIG_FRAC;
						opi_q      <= '0;
						phase_q    <= PH_ACT;
						state_q    <= ST_F_RD;
					end else begin
						state_q <= ST_RP_WAIT;
					end
				end
				ST_RP_WAIT: begin
					fx_q    <= MB'($signed(hist_rdata)) <<< SIG_FRAC;
					ridx_q  <= (LW'(ridx_q) + LW'(1) == hlen) ? '0 : ridx_q + AW'(1);
					rcnt_q  <= rcnt_q - LW'(1);
					opi_q   <= '0;
					state_q <= ST_F_RD;
				end
				ST_F_RD: state_q <= ST_F_LO;
				ST_F_LO: begin
					p_lo_q  <= prod;
					ch_q    <= CH_W'($signed(coef_rdata) >>> 16);
					state_q <= ST_F_HI;
				end
				ST_F_HI: begin
					p_hi_q  <= prod;
					state_q <= ST_F_ACC;
				end
				ST_F_ACC: begin
					unique case (slot)
						2'd0: y_q <= y_sat;
						2'd1: t_q <= res;
						2'd2: begin
							if (phase_q == PH_ACT) begin
								act_mem_q[sec] <= m_sat;
							end else begin
								inc_mem_q[sec] <= m_sat;
							end
							fx_q <= MB'(y_q);
						end
						default: ;
					endcase
					if (opi_q == 3'd5) begin
						unique case (phase_q)
							PH_REPLAY: state_q <= ST_RP_RD;
							PH_ACT: begin
								if (fading_q) begin
									yold_q  <= y_q;
									fx_q    <= MB'(xs_q) <<< SIG_FRAC;
									opi_q   <= '0;
									phase_q <= PH_INC;
									state_q <= ST_F_RD;
								end else begin
									yfin_q  <= MB'(y_q);
									state_q <= ST_FIN;
								end
							end
							PH_INC: state_q <= ST_XF_MUL;
							default: state_q <= ST_IDLE;
						endcase
					end else begin
						opi_q   <= opi_q + 3'd1;
						state_q <= ST_F_RD;
					end
				end
				ST_XF_MUL: begin
					p_lo_q  <= prod;
					state_q <= ST_XF_SET;
				end
				ST_XF_SET: begin
					neg_q      <= p_lo_q[PW-1];
					dq_q       <= DVW'(num_mag) + DVW'(den >> 1);
					dvs_q      <= den;
					rem_q      <= '0;
					dcnt_q     <= '0;
					div_gain_q <= 1'b0;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= dbit ? LEN16_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[LEN16_W-1:0];
					dq_q   <= {dq_q[DVW-2:0], dbit};
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(DVW - 1)) begin
						state_q <= div_gain_q ? ST_GAIN_END : ST_XF_END;
					end
				end
				ST_GAIN_END: begin
					step_q  <= neg_q ? -$signed({1'b0, dq_q[GAIN_W:0]})
						: $signed({1'b0, dq_q[GAIN_W:0]});
					state_q <= ST_IDLE;
				end
				ST_XF_END: begin
					yfin_q <= MB'((MB+1)'(yold_q) + qsig);
					if (fade_end) begin
						act_mem_q  <= inc_mem_q;
						act_mode_q <= inc_mode_q;
						fading_q   <= 1'b0;
						fade_pos_q <= '0;
					end else begin
						fade_pos_q <= fade_pos_q + LEN16_W'(1);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					hpos_q  <= AW'(np);
					hfill_q <= (hfill_q < hlen) ? hfill_q + LW'(1) : hlen;
					if (ramp_left_q != '0) begin
						ramp_left_q <= ramp_left_q - LEN16_W'(1);
						gain_now_q  <= (ramp_left_q == LEN16_W'(1)) ? gain_goal_q
							: nsum[GAIN_W-1:0];
					end
					state_q <= ST_G_LO;
				end
				ST_G_LO: begin
					p_lo_q  <= prod;
					state_q <= ST_G_HI;
				end
				ST_G_HI: begin
					p_hi_q  <= prod;
					state_q <= ST_G_OUT;
				end
				ST_G_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						out_q      <= o_sat;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TW'(out_q);

endmodule
`default_nettype wire

[design/scb_checker.sv]
// Port-level checks of the shelf cascade crossfade boost block, bound to its top level.
`default_nettype none
module scb_checker #(
	parameter int OUT_TW = 24
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [scb_pkg::REQ_W-1:0] s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [OUT_TW-1:0]         m_tdata
);
	import scb_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// An accepted audio item occupies the filter engine, so input ready drops after it.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_SAMPLE |=> !s_tready)
		else $error("input ready right after an audio item");

	// A new result only comes from work in progress, never straight from idle.
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while the block was idle");

endmodule

bind shelf_cascade_crossfade_boost scb_checker #(.OUT_TW(OUT_TW)) u_scb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the shelf cascade crossfade boost block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import scb_pkg::*;

	localparam int IN_TW  = 96;
	localparam int OUT_TW = 24;
	localparam int LIMIT  = 4000000;
	localparam int HDEPTH = 4096;
	localparam int NCOEF  = 36;

	typedef struct {
		req_t             req;
		logic [23:0]      samp;
		logic [1:0]       amp;
		logic [1:0]       emph;
		logic [23:0]      gain;
		logic [5:0]       cidx;
		logic [31:0]      cval;
	} audio_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TW-1:0]      s_tdata = '0;
	logic [REQ_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_TW-1:0]     m_tdata;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	shelf_cascade_crossfade_boost i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Predicted block state.
	longint coefs [NCOEF];
	int     hist_ram [HDEPTH];
	int     hist_wp, hist_fill;
	longint act_mem [2];
	longint inc_mem [2];
	int     act_mode, inc_mode, want_mode;
	bit     fading;
	int     fade_pos;
	longint gain_now, gain_goal, gain_step;
	int     ramp_left;
	int     hist_len_reg, fade_len_reg, ramp_len_reg;

	audio_item_t pending_items [$];
	logic [23:0] expected_out [$];
	audio_item_t cur_item;
	int          send_gap;
	int          recv_wait;
	int          hold_left;
	bit          held_once;
	bit          calm;
	int          outs_seen;
	int          errors;
	int          cycles;
	logic [23:0] last_gain;

	function automatic longint clip(longint v, int bits);
		longint hi, lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// Product of a signal and a coefficient, rounded half up after a right shift by s.
	function automatic longint mac_round(longint a, longint c, int s);
		longint ch, cl, q;
		ch = c >>> 16;
		cl = c - ch * 65536;
		q  = a * cl + (64'sd1 <<< (s - 1));
		return (a * ch + (q >>> 16)) >>> (s - 16);
	endfunction

	function automatic longint shelf_pair(ref longint mem [2], input int mode, input longint x);
		longint y;
		int     base;
		for (int k = 0; k < 2; k++) begin
			base   = mode * 6 + k * 3;
			y      = clip(mac_round(x, coefs[base], 28) + mem[k], MEM_BITS);
			mem[k] = clip(mac_round(x, coefs[base + 1], 28) - mac_round(y, coefs[base + 2], 28),
				MEM_BITS);
			x = y;
		end
		return x;
	endfunction

	function automatic int hist_span();
		if (hist_len_reg < 1) return 1;
		if (hist_len_reg > HDEPTH) return HDEPTH;
		return hist_len_reg;
	endfunction

	function automatic void replay_history();
		int len, pos, fill, idx;
		longint dummy;
		len  = hist_span();
		pos  = hist_wp >= len ? 0 : hist_wp;
		fill = hist_fill > len ? len : hist_fill;
		idx  = (pos + len - fill) % len;
		inc_mode = want_mode;
		inc_mem[0] = 0;
		inc_mem[1] = 0;
		for (int i = 0; i < fill; i++) begin
			dummy = shelf_pair(inc_mem, inc_mode, longint'(hist_ram[idx]) * 256);
			idx = (idx + 1 == len) ? 0 : idx + 1;
		end
		fade_pos = 0;
		fading = 1'b1;
	endfunction

	function automatic void reset_state();
		foreach (coefs[i]) coefs[i] = 0;
		hist_wp = 0;
		hist_fill = 0;
		act_mem[0] = 0; act_mem[1] = 0;
		inc_mem[0] = 0; inc_mem[1] = 0;
		act_mode = 0; inc_mode = 0; want_mode = 0;
		fading = 1'b0;
		fade_pos = 0;
		gain_now = 64'sd1 <<< 28;
		gain_goal = gain_now;
		gain_step = 0;
		ramp_left = 0;
		hist_len_reg = 1024;
		fade_len_reg = 480;
		ramp_len_reg = 480;
	endfunction

	// Updates the predicted state for one accepted item and queues its output, if any.
	function automatic void predict_item(audio_item_t it);
		int     mode, t, e, len, f, r;
		longint g, goal, xf, y, nxt, den, p, num, q;
		case (it.req)
			REQ_CTRL: begin
				t = (it.amp == 2'd3) ? 1 : int'(it.amp);
				e = (it.emph >= 2'd2) ? 0 : int'(it.emph);
				mode = 2 * t + e;
				want_mode = mode < 6 ? mode : 0;
				g = longint'(it.gain);
				if (g < (64'sd1 <<< 20)) g = 64'sd1 <<< 20;
				goal = g <<< 8;
				if (goal != gain_goal) begin
					r = ramp_len_reg < 1 ? 1 : ramp_len_reg;
					gain_goal = goal;
					ramp_left = r;
					gain_step = (gain_goal - gain_now) / longint'(r);
				end
			end
			REQ_COEF: begin
				if (it.cidx < NCOEF) coefs[it.cidx] = longint'($signed(it.cval));
			end
			REQ_SAMPLE: begin
				xf = longint'($signed(it.samp)) * 256;
				if (!fading && act_mode != want_mode) replay_history();
				y = shelf_pair(act_mem, act_mode, xf);
				if (fading) begin
					f   = fade_len_reg < 2 ? 2 : fade_len_reg;
					nxt = shelf_pair(inc_mem, inc_mode, xf);
					den = f - 1;
					p   = fade_pos < f - 1 ? longint'(fade_pos) : den;
					num = (nxt - y) * p;
					q   = num >= 0 ? (num + den / 2) / den : -((-num + den / 2) / den);
					y  += q;
					if (fade_pos + 1 >= f) begin
						act_mem[0] = inc_mem[0];
						act_mem[1] = inc_mem[1];
						act_mode = inc_mode;
						fading = 1'b0;
						fade_pos = 0;
					end else begin
						fade_pos++;
					end
				end
				len = hist_span();
				if (hist_wp >= len) hist_wp = 0;
				hist_ram[hist_wp] = int'($signed(it.samp));
				hist_wp++;
				if (hist_wp >= len) hist_wp = 0;
				if (hist_fill < len) hist_fill++;
				else hist_fill = len;
				if (ramp_left != 0) begin
					gain_now += gain_step;
					ramp_left--;
					if (ramp_left == 0) gain_now = gain_goal;
				end
				expected_out.push_back(24'(clip(mac_round(y, gain_now, 36), 24)));
			end
			default: ;
		endcase
	endfunction

	function automatic logic [IN_TW-1:0] pack_fields(audio_item_t it);
		return {6'd0, it.cval, it.cidx, it.gain, it.emph, it.amp, it.samp};
	endfunction

	function automatic audio_item_t random_item();
		audio_item_t it;
		int r;
		it.samp = 24'($urandom);
		it.amp  = 2'($urandom);
		it.emph = 2'($urandom);
		it.gain = 24'($urandom);
		it.cidx = 6'($urandom);
		it.cval = $urandom;
		r = $urandom_range(0, 99);
		if (r < 76) begin
			it.req = REQ_SAMPLE;
			if ($urandom_range(0, 9) == 0) it.samp = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
		end else if (r < 81) begin
			it.req = REQ_CTRL;
			if ($urandom_range(0, 3) == 0) it.gain = last_gain;
			else if ($urandom_range(0, 3) != 0) it.gain = 24'($urandom_range(1048576, 4194304));
			last_gain = it.gain;
		end else if (r < 97) begin
			it.req = REQ_COEF;
			if ($urandom_range(0, 9) != 0) it.cidx = 6'($urandom_range(0, NCOEF - 1));
			if ($urandom_range(0, 4) != 0) it.cval = 32'($urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
		end else begin
			it.req = REQ_NONE;
		end
		return it;
	endfunction

	function automatic audio_item_t make_item(req_t rq, logic [23:0] samp, logic [1:0] amp,
		logic [1:0] emph, logic [23:0] gain, logic [5:0] cidx, logic [31:0] cval);
		audio_item_t it;
		it.req = rq; it.samp = samp; it.amp = amp; it.emph = emph;
		it.gain = gain; it.cidx = cidx; it.cval = cval;
		return it;
	endfunction

	task automatic report_mismatch(input logic [23:0] got, input logic [23:0] want);
		$display("mismatch on out_sample #%0d: got %0d, expected %0d", outs_seen,
			$signed(got), $signed(want));
		errors++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		case (idx)
			REG_HISTORY_LENGTH: hist_len_reg = value & 16'h1fff;
			REG_FADE_LENGTH:    fade_len_reg = value & 16'hffff;
			default:            ramp_len_reg = value & 16'hffff;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || expected_out.size() != 0) @(posedge clk);
		// A gain change can keep the divider busy without producing output.
		repeat (200) @(posedge clk);
	endtask

	// Sender: one item per handshake, with a random gap drawn for each item outside the calm phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) predict_item(cur_item);
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					s_tdata  <= pack_fields(cur_item);
					s_tuser  <= cur_item.req;
					s_tvalid <= 1'b1;
					send_gap <= calm ? 0 : $urandom_range(0, 4);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls per result outside the calm phase and one long hold-off to back the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			recv_wait <= 0;
			hold_left <= 0;
			held_once <= 1'b0;
			outs_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					$display("unexpected out_sample %0d", $signed(m_tdata[23:0]));
					errors++;
				end else begin
					logic [23:0] want;
					want = expected_out.pop_front();
					if (m_tdata[23:0] !== want) report_mismatch(m_tdata[23:0], want);
				end
				outs_seen <= outs_seen + 1;
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (!held_once && outs_seen == 300) begin
				held_once <= 1'b1;
				hold_left <= 1500;
				m_tready  <= 1'b0;
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready && !calm) recv_wait <= $urandom_range(0, 4);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int hist_set [6] = '{8191, 300, 40, 16, 1, 0};
		int fade_set [6] = '{0, 65535, 2, 3, 480, 40};
		int ramp_set [6] = '{0, 65535, 1, 7, 480, 300};
		int count;
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		last_gain = 24'h100000;
		reset_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			calm = (ph == 4);
			// History length only shrinks after samples exist, so replay never reads stale entries.
			write_reg(REG_HISTORY_LENGTH, hist_set[ph]);
			write_reg(REG_FADE_LENGTH, fade_set[ph]);
			write_reg(REG_RAMP_LENGTH, ramp_set[ph]);
			if (ph == 0) begin
				for (int i = 0; i < NCOEF; i++)
					pending_items.push_back(make_item(REQ_COEF, 24'($urandom), 2'($urandom),
						2'($urandom), 24'($urandom), 6'(i),
						32'($urandom_range(0, 32'h2000_0000) - 32'h1000_0000)));
				pending_items.push_back(make_item(REQ_SAMPLE, 24'h7fffff, 0, 0, 0, 0, 0));
				pending_items.push_back(make_item(REQ_SAMPLE, 24'h800000, 3, 3, 24'hffffff, 63, 0));
				pending_items.push_back(make_item(REQ_CTRL, 0, 2'd3, 2'd1, 24'hffffff, 0, 0));
				pending_items.push_back(make_item(REQ_SAMPLE, 24'h000001, 0, 0, 0, 0, 0));
				pending_items.push_back(make_item(REQ_CTRL, 0, 2'd2, 2'd2, 24'h000000, 0, 0));
				pending_items.push_back(make_item(REQ_SAMPLE, 24'hffffff, 0, 0, 0, 0, 0));
				pending_items.push_back(make_item(REQ_CTRL, 0, 2'd0, 2'd3, 24'h0fffff, 0, 0));
				pending_items.push_back(make_item(REQ_COEF, 0, 0, 0, 0, 6'd36, 32'h7fffffff));
				pending_items.push_back(make_item(REQ_COEF, 0, 0, 0, 0, 6'd63, 32'h80000000));
				pending_items.push_back(make_item(REQ_COEF, 0, 0, 0, 0, 6'd0, 32'h7fffffff));
				pending_items.push_back(make_item(REQ_COEF, 0, 0, 0, 0, 6'd5, 32'h80000000));
				pending_items.push_back(make_item(REQ_NONE, 24'hffffff, 3, 3, 24'hffffff, 63, '1));
				pending_items.push_back(make_item(REQ_SAMPLE, 24'h7fffff, 0, 0, 0, 0, 0));
				pending_items.push_back(make_item(REQ_CTRL, 0, 2'd1, 2'd0, 24'h100000, 0, 0));
				pending_items.push_back(make_item(REQ_SAMPLE, 24'h800000, 0, 0, 0, 0, 0));
				pending_items.push_back(make_item(REQ_SAMPLE, 24'h000000, 0, 0, 0, 0, 0));
			end
			count = (ph == 0) ? 150 : 210;
			for (int i = 0; i < count; i++) pending_items.push_back(random_item());
		end
		while (pending_items.size() != 0 || s_tvalid || expected_out.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

[shelf_cascade_crossfade_boost.f]
design/scb_pkg.sv
design/scb_ram.sv
design/shelf_cascade_crossfade_boost.sv
design/scb_checker.sv
bench/tb_top.sv
